// File: rtl/core/rss_pkg.sv
`timescale 1ns / 1ps

package rss_pkg;

  // Operation codes carried in the kind field of a request.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PICK   = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // Status codes carried in the status field of a response.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_MISS  = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  localparam int VALUE_W = 32;
  localparam int DRAW_W  = 16;
  localparam int OCC_W   = 7;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
    logic [DRAW_W-1:0]         random_draw;
  } request_t;

  typedef struct packed {
    logic                      done_res;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] element;
    logic [OCC_W-1:0]          occupancy;
  } response_t;

endpackage

// File: rtl/core/rss_out_reg.sv
`timescale 1ns / 1ps

// Response holding register. The sequencer loads it only when it is free,
// that is empty or being emptied by a transfer in the same cycle.
module rss_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rss_pkg::response_t data,
  output logic               free,
  output logic               response_valid,
  input  logic               response_stall,
  output rss_pkg::response_t response
);

  assign free = !response_valid || !response_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_valid <= 1'b0;
    end else if (load) begin
      response_valid <= 1'b1;
    end else if (!response_stall) begin
      response_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      response <= data;
    end
  end

endmodule

// File: rtl/core/random_sample_set.sv
`timescale 1ns / 1ps

// Set of distinct 32-bit signed values with insert, remove and random pick.
// A request transfer carries kind, value and random_draw; every request
// yields exactly one response transfer with done_res, status, element and
// occupancy (the element count after the operation).
// Requests are taken one at a time: request_stall is low only while the
// sequencer is idle. Insert and remove scan the live entries in the element
// memory one per cycle through its single read port; an insert into an
// empty set appends without a scan, and a remove that hits then reads the
// last entry to fill the vacated slot. Get random reads one entry, and an
// unused kind reads none.
// The finished response sits in an output register, so the next request is
// taken while a response still waits on response_stall; the sequencer holds
// a second finished response until that register is free.
// Reset clears the element count and the handshake state; the element
// memory needs no clearing since only slots below the count are ever read.
module random_sample_set #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  rss_pkg::request_t  request,
  output logic               response_valid,
  input  logic               response_stall,
  output rss_pkg::response_t response
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PROD_W = rss_pkg::DRAW_W + CNT_W;
  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MOVE = 5'b00100,
    ST_PICK = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] scan_idx, scan_idx_next;
  logic [ADDR_W-1:0] slot, slot_next;
  logic [1:0]        kind_q;
  logic signed [rss_pkg::VALUE_W-1:0] value_q;
  rss_pkg::response_t res, res_next;

  // Element memory: one write port, one registered read port.
  logic signed [rss_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic signed [rss_pkg::VALUE_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic signed [rss_pkg::VALUE_W-1:0] wr_data;

  logic              accept;
  logic              load;
  logic              out_free;
  logic              scan_last;
  logic [ADDR_W-1:0] last_idx;
  logic [PROD_W-1:0] pick_prod;

  assign request_stall = (state != ST_IDLE);
  assign accept        = request_valid && (state == ST_IDLE);

  // The scan reaches the last live entry when its index is count - 1.
  assign scan_last = (CNT_W'(scan_idx) == count - CNT_W'(1));
  assign last_idx  = ADDR_W'(count - CNT_W'(1));

  // Pick index is (draw * count) >> 16, always below the count.
  assign pick_prod = PROD_W'(request.random_draw) * PROD_W'(count);

  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_idx_next = scan_idx;
    slot_next     = slot;
    res_next      = res;
    rd_addr       = scan_idx;
    wr_en         = 1'b0;
    wr_addr       = count[ADDR_W-1:0];
    wr_data       = value_q;
    load          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next           = '0;
          res_next.occupancy = rss_pkg::OCC_W'(count);
          case (request.kind)
            rss_pkg::KIND_INSERT: begin
              if (count == '0) begin
                // Empty set: append at slot zero without scanning.
                wr_en              = 1'b1;
                wr_addr            = '0;
                wr_data            = request.value;
                count_next         = CNT_W'(1);
                res_next.done_res  = 1'b1;
                res_next.occupancy = rss_pkg::OCC_W'(1);
                state_next         = ST_FIN;
              end else begin
                rd_addr       = '0;
                scan_idx_next = '0;
                state_next    = ST_SCAN;
              end
            end
            rss_pkg::KIND_REMOVE: begin
              if (count == '0) begin
                res_next.status = rss_pkg::STATUS_MISS;
                state_next      = ST_FIN;
              end else begin
                rd_addr       = '0;
                scan_idx_next = '0;
                state_next    = ST_SCAN;
              end
            end
            rss_pkg::KIND_PICK: begin
              if (count == '0) begin
                res_next.status = rss_pkg::STATUS_EMPTY;
                state_next      = ST_FIN;
              end else begin
                rd_addr    = pick_prod[rss_pkg::DRAW_W +: ADDR_W];
                state_next = ST_PICK;
              end
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_data == value_q) begin
          slot_next = scan_idx;
          if (kind_q == rss_pkg::KIND_REMOVE) begin
            rd_addr    = last_idx;
            state_next = ST_MOVE;
          end else begin
            res_next.status = rss_pkg::STATUS_MISS;
            state_next      = ST_FIN;
          end
        end else if (scan_last) begin
          if (kind_q == rss_pkg::KIND_INSERT) begin
            if (count >= CAP_COUNT) begin
              res_next.status = rss_pkg::STATUS_FULL;
            end else begin
              wr_en              = 1'b1;
              count_next         = count + CNT_W'(1);
              res_next.done_res  = 1'b1;
              res_next.occupancy = rss_pkg::OCC_W'(count + CNT_W'(1));
            end
          end else begin
            res_next.status = rss_pkg::STATUS_MISS;
          end
          state_next = ST_FIN;
        end else begin
          scan_idx_next = scan_idx + ADDR_W'(1);
          rd_addr       = scan_idx + ADDR_W'(1);
        end
      end

      ST_MOVE: begin
        // rd_data holds the last live entry; it fills the vacated slot.
        wr_en              = 1'b1;
        wr_addr            = slot;
        wr_data            = rd_data;
        count_next         = count - CNT_W'(1);
        res_next.done_res  = 1'b1;
        res_next.occupancy = rss_pkg::OCC_W'(count - CNT_W'(1));
        state_next         = ST_FIN;
      end

      ST_PICK: begin
        res_next.element  = rd_data;
        res_next.done_res = 1'b1;
        state_next        = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    slot     <= slot_next;
    res      <= res_next;
    if (accept) begin
      kind_q  <= request.kind;
      value_q <= request.value;
    end
  end

  // A write may meet a read of the same entry; that read's data is unused,
  // as an operation writes at its last step and its used reads precede it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  rss_out_reg u_out_reg (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .data           (res),
    .free           (out_free),
    .response_valid (response_valid),
    .response_stall (response_stall),
    .response       (response)
  );

  // The count never passes the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("element count exceeds capacity");

  // The scan only ever visits live entries.
  a_scan_live : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CNT_W'(scan_idx) < count))
    else $error("scan index beyond live entries");

  // A move of the last entry only happens on a non-empty set.
  a_move_nonempty : assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |-> (count != '0))
    else $error("move step with empty set");

  // The count steps by at most one per cycle.
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) ||
                     count == $past(count) + CNT_W'(1) ||
                     count + CNT_W'(1) == $past(count)))
    else $error("element count jumped");

  // A loaded response is offered in the next cycle.
  a_load_valid : assert property (@(posedge clk) disable iff (rst)
    load |=> response_valid)
    else $error("loaded response not offered");

endmodule
